>>> sv/decr_pkg.sv
// Package for the disc collision resolver: transaction payload types,
// pipeline context types and stage counts. No dependencies.
package decr_pkg;

	// Pipeline depths of the iterative sections
	localparam int SQRT_STEPS = 32;
	localparam int DIV_STAGES = 36;

	typedef struct packed {
		logic signed [31:0] a_pos_x;
		logic signed [31:0] a_pos_y;
		logic signed [31:0] a_vel_x;
		logic signed [31:0] a_vel_y;
		logic [30:0]        a_radius;
		logic [30:0]        a_mass;
		logic signed [31:0] b_pos_x;
		logic signed [31:0] b_pos_y;
		logic signed [31:0] b_vel_x;
		logic signed [31:0] b_vel_y;
		logic [30:0]        b_radius;
		logic [30:0]        b_mass;
	} decr_in_t;

	typedef struct packed {
		logic signed [31:0] new_a_pos_x;
		logic signed [31:0] new_a_pos_y;
		logic signed [31:0] new_a_vel_x;
		logic signed [31:0] new_a_vel_y;
		logic signed [31:0] new_b_pos_x;
		logic signed [31:0] new_b_pos_y;
		logic signed [31:0] new_b_vel_x;
		logic signed [31:0] new_b_vel_y;
		logic               degenerate;
	} decr_out_t;

	// Context carried through the square root section
	typedef struct packed {
		decr_in_t    item;
		logic        ok;
		logic [31:0] msum;
		logic [31:0] adx;
		logic [31:0] ady;
		logic        sx;
		logic        sy;
		logic [63:0] dotm;
		logic        dotneg;
		logic [31:0] rsum;
		logic [63:0] d2;
	} decr_mid_t;

	// Context carried through the divider section
	typedef struct packed {
		decr_in_t item;
		logic     ok;
		logic     ss;
		logic     sx;
		logic     sy;
		logic     dotneg;
	} decr_ctx_t;

endpackage

>>> sv/disc_elastic_collision_resolve_top.sv
// Disc collision resolver: fully pipelined separation push and elastic impulse.
// Depends on decr_pkg (payload structs, context structs, stage counts).
//
// Usage:
//   Input channel in_valid / in_stall / in_data carries one disc pair per
//   transaction; output channel out_valid / out_stall / out_data carries the
//   corrected pair and the degenerate flag. A transaction moves at a clock
//   edge with valid high and stall low.
// Throughput: one transaction per cycle while the output is not stalled. A
//   transaction passes through the 32-stage square root (one result bit per
//   stage) and the 36-stage dividers (one quotient bit per stage: an overflow
//   check plus 35 bits for the impulse, 31 bits for the push) to the output
//   register.
// Stall: when the output register holds a result that is stalled, the whole
//   pipeline freezes and in_stall rises; nothing is dropped or repeated.
// Reset: arst_n clears every stage valid bit; payload registers are not reset.
// Degenerate pairs (coincident centers, wide differences, zero mass sum or
//   result overflow) return the input positions and velocities with
//   degenerate set.
module disc_elastic_collision_resolve_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  decr_pkg::decr_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output decr_pkg::decr_out_t out_data
);
	import decr_pkg::*;

	localparam logic [34:0] IMP_MAX = 35'd8589934592;

	logic adv;

	// Stage 1: differences and range checks
	logic signed [32:0] dx_c, dy_c, dvx_c, dvy_c;
	logic [31:0]        msum_c;
	logic               v_s1, ok_s1;
	decr_in_t           item_s1;
	logic signed [31:0] dx_s1, dy_s1, dvx_s1, dvy_s1;
	logic [31:0]        msum_s1;

	// Stage 2: squares and dot terms
	logic [31:0]        adx_c, ady_c;
	logic               v_s2;
	decr_mid_t          mid_s2;
	logic [63:0]        sqx_s2, sqy_s2;
	logic signed [63:0] t1_s2, t2_s2;

	// Square root section
	logic               sq_v [0:SQRT_STEPS];
	decr_mid_t          sq_ctx [0:SQRT_STEPS];
	logic [63:0]        sq_n [0:SQRT_STEPS];
	logic [63:0]        sq_r [0:SQRT_STEPS];
	logic signed [64:0] dot_c;
	decr_mid_t          sq_in_c;

	// Stage 4: push numerators and partial products
	logic signed [32:0] s_c;
	logic [31:0]        d_c;
	logic [31:0]        abs_s_c;
	decr_mid_t          mid4_c;
	logic               v_s4;
	decr_mid_t          mid_s4;
	logic               ss_s4;
	logic [31:0]        d_s4;
	logic [63:0]        pnx_s4, pny_s4, denl_s4, denh_s4;
	logic [63:0]        dxl_s4, dxh_s4, dyl_s4, dyh_s4;

	// Stage 5: wide sums
	logic               v_s5;
	decr_ctx_t          ctx_s5;
	logic [31:0]        m2a_s5, m2b_s5;
	logic [32:0]        pden_s5;
	logic [63:0]        pnx_s5, pny_s5;
	logic [95:0]        den_s5, npx_s5, npy_s5;

	// Stage 6: mass products
	logic               v_s6;
	decr_ctx_t          ctx_s6;
	logic [32:0]        pden_s6;
	logic [63:0]        pnx_s6, pny_s6;
	logic [95:0]        den_s6;
	logic [63:0]        pp_s6 [4][3];

	// Divider section
	logic               dv_v [0:DIV_STAGES];
	decr_ctx_t          dv_ctx [0:DIV_STAGES];
	logic [32:0]        dv_pden [0:DIV_STAGES];
	logic [95:0]        dv_den [0:DIV_STAGES];
	logic [30:0]        dv_pnum [0:DIV_STAGES][2];
	logic [32:0]        dv_pr [0:DIV_STAGES][2];
	logic [30:0]        dv_pq [0:DIV_STAGES][2];
	logic [34:0]        dv_inum [0:DIV_STAGES][4];
	logic [95:0]        dv_ir [0:DIV_STAGES][4];
	logic [34:0]        dv_iq [0:DIV_STAGES][4];
	logic               dv_ovf [0:DIV_STAGES][4];
	logic [127:0]       num_c [4];

	// Output stage
	logic signed [35:0] res_c [8];
	logic               fit_c;
	logic               ok_c;
	decr_out_t          out_c;
	logic               out_v_q;
	decr_out_t          out_data_q;

	function automatic logic signed [35:0] adj(logic signed [31:0] base, logic [34:0] mag,
			logic neg, logic sub);
		logic signed [35:0] delta;
		logic signed [35:0] b;
		delta = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		b = 36'(base);
		return sub ? b - delta : b + delta;
	endfunction

	// Advance the whole pipeline unless the output transaction is stalled
	assign adv      = !out_v_q || !out_stall;
	assign in_stall = !adv;

	// Form differences and mass sum
	always_comb begin
		dx_c   = {in_data.a_pos_x[31], in_data.a_pos_x} - {in_data.b_pos_x[31], in_data.b_pos_x};
		dy_c   = {in_data.a_pos_y[31], in_data.a_pos_y} - {in_data.b_pos_y[31], in_data.b_pos_y};
		dvx_c  = {in_data.a_vel_x[31], in_data.a_vel_x} - {in_data.b_vel_x[31], in_data.b_vel_x};
		dvy_c  = {in_data.a_vel_y[31], in_data.a_vel_y} - {in_data.b_vel_y[31], in_data.b_vel_y};
		msum_c = {1'b0, in_data.a_mass} + {1'b0, in_data.b_mass};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= in_data;
			ok_s1   <= (dx_c[32] == dx_c[31]) && (dy_c[32] == dy_c[31]) &&
			           (dvx_c[32] == dvx_c[31]) && (dvy_c[32] == dvy_c[31]) &&
			           (msum_c != 32'd0);
			dx_s1   <= dx_c[31:0];
			dy_s1   <= dy_c[31:0];
			dvx_s1  <= dvx_c[31:0];
			dvy_s1  <= dvy_c[31:0];
			msum_s1 <= msum_c;
		end
	end

	// Square the offsets and form the dot terms
	assign adx_c = dx_s1[31] ? 32'(-dx_s1) : 32'(dx_s1);
	assign ady_c = dy_s1[31] ? 32'(-dy_s1) : 32'(dy_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mid_s2.item   <= item_s1;
			mid_s2.ok     <= ok_s1;
			mid_s2.msum   <= msum_s1;
			mid_s2.adx    <= adx_c;
			mid_s2.ady    <= ady_c;
			mid_s2.sx     <= dx_s1[31];
			mid_s2.sy     <= dy_s1[31];
			mid_s2.dotm   <= '0;
			mid_s2.dotneg <= 1'b0;
			mid_s2.rsum   <= {1'b0, item_s1.a_radius} + {1'b0, item_s1.b_radius};
			mid_s2.d2     <= '0;
			sqx_s2        <= adx_c * adx_c;
			sqy_s2        <= ady_c * ady_c;
			t1_s2         <= dvx_s1 * dx_s1;
			t2_s2         <= dvy_s1 * dy_s1;
		end
	end

	// Sum squared distance and dot product, enter the square root
	assign dot_c = {t1_s2[63], t1_s2} + {t2_s2[63], t2_s2};

	always_comb begin
		sq_in_c        = mid_s2;
		sq_in_c.dotm   = dot_c[64] ? 64'(-dot_c) : dot_c[63:0];
		sq_in_c.dotneg = dot_c[64];
		sq_in_c.d2     = sqx_s2 + sqy_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v[0] <= 1'b0;
		end else if (adv) begin
			sq_v[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_ctx[0] <= sq_in_c;
			sq_n[0]   <= sq_in_c.d2;
			sq_r[0]   <= '0;
		end
	end

	// Integer square root: one result bit per stage
	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
		logic [63:0] trial;

		assign trial = sq_r[k] + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v[k+1] <= 1'b0;
			end else if (adv) begin
				sq_v[k+1] <= sq_v[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_ctx[k+1] <= sq_ctx[k];
				if (sq_n[k] >= trial) begin
					sq_n[k+1] <= sq_n[k] - trial;
					sq_r[k+1] <= (sq_r[k] >> 1) + BIT;
				end else begin
					sq_n[k+1] <= sq_n[k];
					sq_r[k+1] <= sq_r[k] >> 1;
				end
			end
		end
	end

	// Overlap, push numerators and split products
	always_comb begin
		d_c       = sq_r[SQRT_STEPS][31:0];
		s_c       = {1'b0, sq_ctx[SQRT_STEPS].rsum} - {1'b0, d_c};
		abs_s_c   = s_c[32] ? 32'(-s_c) : s_c[31:0];
		mid4_c    = sq_ctx[SQRT_STEPS];
		mid4_c.ok = sq_ctx[SQRT_STEPS].ok && (d_c != 32'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= sq_v[SQRT_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mid_s4    <= mid4_c;
			ss_s4     <= s_c[32];
			d_s4      <= d_c;
			pnx_s4    <= abs_s_c * sq_ctx[SQRT_STEPS].adx;
			pny_s4    <= abs_s_c * sq_ctx[SQRT_STEPS].ady;
			denl_s4   <= sq_ctx[SQRT_STEPS].msum * sq_ctx[SQRT_STEPS].d2[31:0];
			denh_s4   <= sq_ctx[SQRT_STEPS].msum * sq_ctx[SQRT_STEPS].d2[63:32];
			dxl_s4    <= sq_ctx[SQRT_STEPS].dotm[31:0] * sq_ctx[SQRT_STEPS].adx;
			dxh_s4    <= sq_ctx[SQRT_STEPS].dotm[63:32] * sq_ctx[SQRT_STEPS].adx;
			dyl_s4    <= sq_ctx[SQRT_STEPS].dotm[31:0] * sq_ctx[SQRT_STEPS].ady;
			dyh_s4    <= sq_ctx[SQRT_STEPS].dotm[63:32] * sq_ctx[SQRT_STEPS].ady;
		end
	end

	// Combine partial products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s5.item   <= mid_s4.item;
			ctx_s5.ok     <= mid_s4.ok;
			ctx_s5.ss     <= ss_s4;
			ctx_s5.sx     <= mid_s4.sx;
			ctx_s5.sy     <= mid_s4.sy;
			ctx_s5.dotneg <= mid_s4.dotneg;
			m2a_s5        <= {mid_s4.item.a_mass, 1'b0};
			m2b_s5        <= {mid_s4.item.b_mass, 1'b0};
			pden_s5       <= {d_s4, 1'b0};
			pnx_s5        <= pnx_s4;
			pny_s5        <= pny_s4;
			den_s5        <= {32'd0, denl_s4} + {denh_s4, 32'd0};
			npx_s5        <= {32'd0, dxl_s4} + {dxh_s4, 32'd0};
			npy_s5        <= {32'd0, dyl_s4} + {dyh_s4, 32'd0};
		end
	end

	// Multiply by twice the other mass, one 32-bit slice per product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s6  <= ctx_s5;
			pden_s6 <= pden_s5;
			pnx_s6  <= pnx_s5;
			pny_s6  <= pny_s5;
			den_s6  <= den_s5;
			for (int m = 0; m < 3; m++) begin
				pp_s6[0][m] <= npx_s5[m*32 +: 32] * m2b_s5;
				pp_s6[1][m] <= npy_s5[m*32 +: 32] * m2b_s5;
				pp_s6[2][m] <= npx_s5[m*32 +: 32] * m2a_s5;
				pp_s6[3][m] <= npy_s5[m*32 +: 32] * m2a_s5;
			end
		end
	end

	// Assemble impulse numerators and load the dividers
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			num_c[j] = {64'd0, pp_s6[j][0]} + {32'd0, pp_s6[j][1], 32'd0} +
			           {pp_s6[j][2], 64'd0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v[0] <= 1'b0;
		end else if (adv) begin
			dv_v[0] <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_ctx[0]     <= ctx_s6;
			dv_pden[0]    <= pden_s6;
			dv_den[0]     <= den_s6;
			dv_pnum[0][0] <= pnx_s6[30:0];
			dv_pnum[0][1] <= pny_s6[30:0];
			dv_pr[0][0]   <= pnx_s6[63:31];
			dv_pr[0][1]   <= pny_s6[63:31];
			dv_pq[0][0]   <= '0;
			dv_pq[0][1]   <= '0;
			for (int j = 0; j < 4; j++) begin
				dv_inum[0][j] <= num_c[j][34:0];
				dv_ir[0][j]   <= {3'd0, num_c[j][127:35]};
				dv_iq[0][j]   <= '0;
				dv_ovf[0][j]  <= 1'b0;
			end
		end
	end

	// Restoring dividers: overflow check, then one quotient bit per stage
	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		logic [95:0] ir_n [4];
		logic [34:0] iq_n [4];
		logic        ovf_n [4];
		logic [32:0] pr_n [2];
		logic [30:0] pq_n [2];

		if (k == 0) begin : g_ovf
			always_comb begin
				for (int j = 0; j < 4; j++) begin
					ir_n[j]  = dv_ir[k][j];
					iq_n[j]  = dv_iq[k][j];
					ovf_n[j] = dv_ir[k][j] >= dv_den[k];
				end
			end
		end else begin : g_istep
			localparam int BI = DIV_STAGES - 1 - k;
			logic [96:0] t [4];
			always_comb begin
				for (int j = 0; j < 4; j++) begin
					t[j]     = {dv_ir[k][j], dv_inum[k][j][BI]};
					ovf_n[j] = dv_ovf[k][j];
					if (t[j] >= {1'b0, dv_den[k]}) begin
						ir_n[j] = 96'(t[j] - {1'b0, dv_den[k]});
						iq_n[j] = dv_iq[k][j] | (35'd1 << BI);
					end else begin
						ir_n[j] = t[j][95:0];
						iq_n[j] = dv_iq[k][j];
					end
				end
			end
		end

		if (k >= DIV_STAGES - 31) begin : g_pstep
			localparam int BP = DIV_STAGES - 1 - k;
			logic [33:0] t [2];
			always_comb begin
				for (int m = 0; m < 2; m++) begin
					t[m] = {dv_pr[k][m], dv_pnum[k][m][BP]};
					if (t[m] >= {1'b0, dv_pden[k]}) begin
						pr_n[m] = 33'(t[m] - {1'b0, dv_pden[k]});
						pq_n[m] = dv_pq[k][m] | (31'd1 << BP);
					end else begin
						pr_n[m] = t[m][32:0];
						pq_n[m] = dv_pq[k][m];
					end
				end
			end
		end else begin : g_phold
			always_comb begin
				for (int m = 0; m < 2; m++) begin
					pr_n[m] = dv_pr[k][m];
					pq_n[m] = dv_pq[k][m];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[k+1] <= 1'b0;
			end else if (adv) begin
				dv_v[k+1] <= dv_v[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_ctx[k+1]  <= dv_ctx[k];
				dv_pden[k+1] <= dv_pden[k];
				dv_den[k+1]  <= dv_den[k];
				for (int m = 0; m < 2; m++) begin
					dv_pnum[k+1][m] <= dv_pnum[k][m];
					dv_pr[k+1][m]   <= pr_n[m];
					dv_pq[k+1][m]   <= pq_n[m];
				end
				for (int j = 0; j < 4; j++) begin
					dv_inum[k+1][j] <= dv_inum[k][j];
					dv_ir[k+1][j]   <= ir_n[j];
					dv_iq[k+1][j]   <= iq_n[j];
					dv_ovf[k+1][j]  <= ovf_n[j];
				end
			end
		end
	end

	// Apply push and impulse, check range, fall back to pass-through
	always_comb begin
		res_c[0] = adj(dv_ctx[DIV_STAGES].item.a_pos_x, {4'd0, dv_pq[DIV_STAGES][0]},
		               dv_ctx[DIV_STAGES].ss ^ dv_ctx[DIV_STAGES].sx, 1'b0);
		res_c[1] = adj(dv_ctx[DIV_STAGES].item.a_pos_y, {4'd0, dv_pq[DIV_STAGES][1]},
		               dv_ctx[DIV_STAGES].ss ^ dv_ctx[DIV_STAGES].sy, 1'b0);
		res_c[2] = adj(dv_ctx[DIV_STAGES].item.a_vel_x, dv_iq[DIV_STAGES][0],
		               dv_ctx[DIV_STAGES].dotneg ^ dv_ctx[DIV_STAGES].sx, 1'b1);
		res_c[3] = adj(dv_ctx[DIV_STAGES].item.a_vel_y, dv_iq[DIV_STAGES][1],
		               dv_ctx[DIV_STAGES].dotneg ^ dv_ctx[DIV_STAGES].sy, 1'b1);
		res_c[4] = adj(dv_ctx[DIV_STAGES].item.b_pos_x, {4'd0, dv_pq[DIV_STAGES][0]},
		               dv_ctx[DIV_STAGES].ss ^ dv_ctx[DIV_STAGES].sx, 1'b1);
		res_c[5] = adj(dv_ctx[DIV_STAGES].item.b_pos_y, {4'd0, dv_pq[DIV_STAGES][1]},
		               dv_ctx[DIV_STAGES].ss ^ dv_ctx[DIV_STAGES].sy, 1'b1);
		res_c[6] = adj(dv_ctx[DIV_STAGES].item.b_vel_x, dv_iq[DIV_STAGES][2],
		               dv_ctx[DIV_STAGES].dotneg ^ dv_ctx[DIV_STAGES].sx, 1'b0);
		res_c[7] = adj(dv_ctx[DIV_STAGES].item.b_vel_y, dv_iq[DIV_STAGES][3],
		               dv_ctx[DIV_STAGES].dotneg ^ dv_ctx[DIV_STAGES].sy, 1'b0);
		fit_c = 1'b1;
		for (int i = 0; i < 8; i++) begin
			if (!((res_c[i][35:31] == 5'b00000) || (res_c[i][35:31] == 5'b11111))) begin
				fit_c = 1'b0;
			end
		end
		ok_c = dv_ctx[DIV_STAGES].ok && fit_c;
		for (int j = 0; j < 4; j++) begin
			if (dv_ovf[DIV_STAGES][j] || (dv_iq[DIV_STAGES][j] > IMP_MAX)) begin
				ok_c = 1'b0;
			end
		end
		if (ok_c) begin
			out_c.new_a_pos_x = res_c[0][31:0];
			out_c.new_a_pos_y = res_c[1][31:0];
			out_c.new_a_vel_x = res_c[2][31:0];
			out_c.new_a_vel_y = res_c[3][31:0];
			out_c.new_b_pos_x = res_c[4][31:0];
			out_c.new_b_pos_y = res_c[5][31:0];
			out_c.new_b_vel_x = res_c[6][31:0];
			out_c.new_b_vel_y = res_c[7][31:0];
		end else begin
			out_c.new_a_pos_x = dv_ctx[DIV_STAGES].item.a_pos_x;
			out_c.new_a_pos_y = dv_ctx[DIV_STAGES].item.a_pos_y;
			out_c.new_a_vel_x = dv_ctx[DIV_STAGES].item.a_vel_x;
			out_c.new_a_vel_y = dv_ctx[DIV_STAGES].item.a_vel_y;
			out_c.new_b_pos_x = dv_ctx[DIV_STAGES].item.b_pos_x;
			out_c.new_b_pos_y = dv_ctx[DIV_STAGES].item.b_pos_y;
			out_c.new_b_vel_x = dv_ctx[DIV_STAGES].item.b_vel_x;
			out_c.new_b_vel_y = dv_ctx[DIV_STAGES].item.b_vel_y;
		end
		out_c.degenerate = !ok_c;
	end

	// Hold the result until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= dv_v[DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= out_c;
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_data_q;

	// A stalled pipeline keeps the occupancy of stage 1, stage 4 and the divider output in place
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> $stable(v_s1) && $stable(v_s4) && $stable(dv_v[DIV_STAGES]))
		else $error("pipeline moved while stalled");

	// Square root remainder stays within 2r
	assert property (@(posedge clk) disable iff (!arst_n)
		sq_v[SQRT_STEPS] |-> (sq_n[SQRT_STEPS] <= {sq_r[SQRT_STEPS][62:0], 1'b0}))
		else $error("square root remainder out of range");

	// The x push divider ends with its remainder below the divisor
	assert property (@(posedge clk) disable iff (!arst_n)
		(dv_v[DIV_STAGES] && dv_ctx[DIV_STAGES].ok) |->
		(dv_pr[DIV_STAGES][0] < dv_pden[DIV_STAGES]))
		else $error("push divider remainder not below divisor");

endmodule

>>> tb/tb_top.sv
// Testbench for disc_elastic_collision_resolve_top: directed table plus random disc pairs,
// checked against an in-bench predictor of push and elastic impulse.
// Depends on decr_pkg and the top module.
`timescale 1ns / 1ps

module tb_top;
	import decr_pkg::*;

	localparam int LATENCY = 76;
	localparam int N_RANDOM = 830;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct {
		decr_in_t  item;
		logic      has_exp;
		decr_out_t exp;
	} row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	decr_in_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	decr_out_t out_data;

	decr_out_t pending_pairs[$];
	int        mismatch_count = 0;
	int        resolved_count = 0;
	int        degenerate_count = 0;
	longint    cycle_count = 0;
	logic      calm_mode = 1'b0;
	row_t      table_rows[$];

	disc_elastic_collision_resolve_top uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	// Generate the clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("disc_elastic_collision_resolve_top verification failed");
			$finish;
		end
	end

	// Truncating division; huge quotients saturate well past any legal impulse
	function automatic logic signed [63:0] trunc_div(logic signed [127:0] num,
			logic [127:0] den);
		logic [127:0] mag;
		logic [127:0] q;
		mag = num[127] ? -num : num;
		q = mag / den;
		if (q[127:62] != '0) q = 128'h3FFF_FFFF_FFFF_FFFF;
		return num[127] ? -$signed(q[63:0]) : $signed(q[63:0]);
	endfunction

	function automatic logic fits_word(logic signed [63:0] v);
		return v >= -64'sd2147483648 && v <= 64'sd2147483647;
	endfunction

	// Predict the resolved pair for one disc pair
	function automatic decr_out_t resolve_pair(decr_in_t p);
		decr_out_t r;
		logic signed [63:0] dx, dy, dvx, dvy, s, cx, cy, span;
		logic signed [127:0] dot;
		logic signed [63:0] iax, iay, ibx, iby;
		logic signed [63:0] nv[8];
		logic [63:0] d2, root, msum;
		logic [127:0] den, big;
		logic ok;
		dx = 64'(p.a_pos_x) - 64'(p.b_pos_x);
		dy = 64'(p.a_pos_y) - 64'(p.b_pos_y);
		dvx = 64'(p.a_vel_x) - 64'(p.b_vel_x);
		dvy = 64'(p.a_vel_y) - 64'(p.b_vel_y);
		msum = 64'(p.a_mass) + 64'(p.b_mass);
		ok = fits_word(dx) && fits_word(dy) && fits_word(dvx) && fits_word(dvy)
			&& msum != 0;
		if (ok) begin
			d2 = dx * dx + dy * dy;
			root = 0;
			for (int b = 31; b >= 0; b--) begin
				big = 128'(root | (64'd1 << b));
				if (big * big <= 128'(d2)) root = big[63:0];
			end
			span = $signed(root);
			if (root == 0) ok = 1'b0;
		end
		if (ok) begin
			s = 64'(p.a_radius) + 64'(p.b_radius) - span;
			cx = trunc_div(128'(s) * 128'(dx), 128'(2 * root));
			cy = trunc_div(128'(s) * 128'(dy), 128'(2 * root));
			dot = 128'(dvx) * 128'(dx) + 128'(dvy) * 128'(dy);
			den = 128'(msum) * 128'(d2);
			iax = trunc_div(dot * 128'(dx) * 128'(2 * 64'(p.b_mass)), den);
			iay = trunc_div(dot * 128'(dy) * 128'(2 * 64'(p.b_mass)), den);
			ibx = trunc_div(dot * 128'(dx) * 128'(2 * 64'(p.a_mass)), den);
			iby = trunc_div(dot * 128'(dy) * 128'(2 * 64'(p.a_mass)), den);
			// impulses larger than 2^33 count as overflow
			foreach (nv[k]) nv[k] = 0;
			if (iax > 64'sd8589934592 || iax < -64'sd8589934592 ||
				iay > 64'sd8589934592 || iay < -64'sd8589934592 ||
				ibx > 64'sd8589934592 || ibx < -64'sd8589934592 ||
				iby > 64'sd8589934592 || iby < -64'sd8589934592) begin
				ok = 1'b0;
			end else begin
				nv[0] = 64'(p.a_pos_x) + cx; nv[1] = 64'(p.a_pos_y) + cy;
				nv[2] = 64'(p.a_vel_x) - iax; nv[3] = 64'(p.a_vel_y) - iay;
				nv[4] = 64'(p.b_pos_x) - cx; nv[5] = 64'(p.b_pos_y) - cy;
				nv[6] = 64'(p.b_vel_x) + ibx; nv[7] = 64'(p.b_vel_y) + iby;
				foreach (nv[k]) if (!fits_word(nv[k])) ok = 1'b0;
			end
		end
		if (ok) begin
			r = '{nv[0][31:0], nv[1][31:0], nv[2][31:0], nv[3][31:0],
				nv[4][31:0], nv[5][31:0], nv[6][31:0], nv[7][31:0], 1'b0};
		end else begin
			r = '{p.a_pos_x, p.a_pos_y, p.a_vel_x, p.a_vel_y,
				p.b_pos_x, p.b_pos_y, p.b_vel_x, p.b_vel_y, 1'b1};
		end
		return r;
	endfunction

	function automatic decr_out_t pass_through(decr_in_t p);
		return '{p.a_pos_x, p.a_pos_y, p.a_vel_x, p.a_vel_y,
			p.b_pos_x, p.b_pos_y, p.b_vel_x, p.b_vel_y, 1'b1};
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatch_count++;
		$display("mismatch %s at cycle %0d: got %h expected %h", what, cycle_count,
			got, want);
	endtask

	// Random pair: mostly small, touching discs; sometimes full-range noise
	function automatic decr_in_t random_pair();
		decr_in_t p;
		int mode;
		logic [31:0] base_x, base_y;
		p = $bits(decr_in_t)'({$urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
		mode = $urandom_range(0, 9);
		if (mode < 7) begin
			base_x = $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
			base_y = $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
			p.a_pos_x = base_x;
			p.a_pos_y = base_y;
			p.b_pos_x = base_x + $signed($urandom_range(0, 32'h0008_0000)) - 32'sh4_0000;
			p.b_pos_y = base_y + $signed($urandom_range(0, 32'h0008_0000)) - 32'sh4_0000;
			p.a_vel_x = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh10_0000;
			p.a_vel_y = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh10_0000;
			p.b_vel_x = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh10_0000;
			p.b_vel_y = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh10_0000;
			p.a_radius = 31'($urandom_range(0, 32'h0004_0000));
			p.b_radius = 31'($urandom_range(0, 32'h0004_0000));
			p.a_mass = 31'($urandom_range(1, 32'h0100_0000));
			p.b_mass = 31'($urandom_range(1, 32'h0100_0000));
		end else if (mode == 7) begin
			// coincident centers
			p.b_pos_x = p.a_pos_x;
			p.b_pos_y = p.a_pos_y;
		end
		if (p.a_mass == 0) p.a_mass = 1;
		if (p.b_mass == 0) p.b_mass = 1;
		return p;
	endfunction

	task automatic add_row(decr_in_t p, logic has_exp);
		row_t r;
		r.item = p;
		r.has_exp = has_exp;
		r.exp = pass_through(p);
		table_rows = {table_rows, r};
	endtask

	task automatic build_table();
		decr_in_t p;
		// Head-on, equal masses, overlapping
		p = '0;
		p.a_pos_x = -32'sh1_0000; p.b_pos_x = 32'sh1_0000;
		p.a_vel_x = 32'sh1_0000; p.b_vel_x = -32'sh1_0000;
		p.a_radius = 31'h1_8000; p.b_radius = 31'h1_8000;
		p.a_mass = 31'h1_0000; p.b_mass = 31'h1_0000;
		add_row(p, 1'b0);
		// Separated discs, pulled together
		p.a_radius = 31'h0; p.b_radius = 31'h0;
		add_row(p, 1'b0);
		// Diagonal, unequal masses
		p = '0;
		p.a_pos_x = 32'sh3_0000; p.a_pos_y = 32'sh4_0000;
		p.a_vel_y = -32'sh2_0000; p.b_vel_x = 32'sh0_8000;
		p.a_radius = 31'h3_0000; p.b_radius = 31'h3_0000;
		p.a_mass = 31'h1; p.b_mass = 31'h7FFF_FFFF;
		add_row(p, 1'b0);
		p.a_mass = 31'h7FFF_FFFF; p.b_mass = 31'h1;
		add_row(p, 1'b0);
		// Max radii, max masses
		p.a_radius = 31'h7FFF_FFFF; p.b_radius = 31'h7FFF_FFFF;
		p.a_mass = 31'h7FFF_FFFF; p.b_mass = 31'h7FFF_FFFF;
		add_row(p, 1'b0);
		// Coincident centers
		p = '0; p.a_mass = 1; p.b_mass = 1;
		add_row(p, 1'b1);
		p.a_pos_x = 32'sh8000_0000; p.b_pos_x = 32'sh8000_0000;
		p.a_pos_y = 32'sh7FFF_FFFF; p.b_pos_y = 32'sh7FFF_FFFF;
		p.a_vel_x = 32'sh7FFF_FFFF; p.b_vel_y = 32'sh8000_0000;
		add_row(p, 1'b1);
		// Wide position difference in x, then y
		p = '0; p.a_mass = 1; p.b_mass = 1;
		p.a_pos_x = 32'sh7FFF_FFFF; p.b_pos_x = 32'sh8000_0000;
		add_row(p, 1'b1);
		p.a_pos_x = 0; p.b_pos_x = 0;
		p.a_pos_y = 32'sh8000_0000; p.b_pos_y = 32'sh0000_0001;
		add_row(p, 1'b1);
		// Wide velocity differences
		p = '0; p.a_mass = 1; p.b_mass = 1; p.a_pos_x = 32'sh1_0000;
		p.a_vel_x = 32'sh7FFF_FFFF; p.b_vel_x = 32'shFFFF_FFFF;
		add_row(p, 1'b1);
		p.a_vel_x = 0; p.b_vel_x = 0;
		p.a_vel_y = 32'sh8000_0000; p.b_vel_y = 32'sh0000_0001;
		add_row(p, 1'b1);
		// Zero mass sum
		p = '0; p.a_pos_x = 32'sh1_0000;
		add_row(p, 1'b1);
		// Push overflows a position at the edge
		p = '0; p.a_mass = 1; p.b_mass = 1;
		p.a_pos_x = 32'sh7FFF_0000; p.b_pos_x = 32'sh7FFE_0000;
		p.a_radius = 31'h7FFF_FFFF; p.b_radius = 31'h7FFF_FFFF;
		add_row(p, 1'b1);
		// Large impulse
		p = '0; p.a_pos_x = 1; p.a_mass = 1; p.b_mass = 31'h7FFF_FFFF;
		p.a_vel_x = 32'sh4000_0000; p.b_vel_x = -32'sh3FFF_FFFF;
		add_row(p, 1'b0);
		// Glancing and separating
		p = '0; p.a_pos_y = 32'sh2_0000; p.a_vel_x = 32'sh5_0000;
		p.a_radius = 31'h1_0000; p.b_radius = 31'h1_8000;
		p.a_mass = 31'h2_0000; p.b_mass = 31'h1_0000;
		add_row(p, 1'b0);
		p.a_vel_y = 32'sh3_0000; p.b_vel_y = -32'sh1_0000;
		add_row(p, 1'b0);
		// Negative coordinates
		p.a_pos_x = -32'sh10_0000; p.a_pos_y = -32'sh10_0000;
		p.b_pos_x = -32'sh10_C000; p.b_pos_y = -32'sh0F_4000;
		add_row(p, 1'b0);
	endtask

	// Send one transaction, idling first at random
	task automatic send_pair(decr_in_t p);
		while (!calm_mode && $urandom_range(0, 99) < 28) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_data <= p;
		in_valid <= 1'b1;
		pending_pairs = {pending_pairs, resolve_pair(p)};
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Stall the output at random
	always @(posedge clk) begin
		out_stall <= !calm_mode && ($urandom_range(0, 99) < 28);
	end

	// Check each result transaction
	always @(posedge clk) begin
		decr_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_pairs.size() == 0) begin
				report_mismatch("unexpected result", out_data.new_a_pos_x, 32'd0);
			end else begin
				want = pending_pairs.pop_front();
				if (out_data.new_a_pos_x !== want.new_a_pos_x)
					report_mismatch("new_a_pos_x", out_data.new_a_pos_x, want.new_a_pos_x);
				if (out_data.new_a_pos_y !== want.new_a_pos_y)
					report_mismatch("new_a_pos_y", out_data.new_a_pos_y, want.new_a_pos_y);
				if (out_data.new_a_vel_x !== want.new_a_vel_x)
					report_mismatch("new_a_vel_x", out_data.new_a_vel_x, want.new_a_vel_x);
				if (out_data.new_a_vel_y !== want.new_a_vel_y)
					report_mismatch("new_a_vel_y", out_data.new_a_vel_y, want.new_a_vel_y);
				if (out_data.new_b_pos_x !== want.new_b_pos_x)
					report_mismatch("new_b_pos_x", out_data.new_b_pos_x, want.new_b_pos_x);
				if (out_data.new_b_pos_y !== want.new_b_pos_y)
					report_mismatch("new_b_pos_y", out_data.new_b_pos_y, want.new_b_pos_y);
				if (out_data.new_b_vel_x !== want.new_b_vel_x)
					report_mismatch("new_b_vel_x", out_data.new_b_vel_x, want.new_b_vel_x);
				if (out_data.new_b_vel_y !== want.new_b_vel_y)
					report_mismatch("new_b_vel_y", out_data.new_b_vel_y, want.new_b_vel_y);
				if (out_data.degenerate !== want.degenerate)
					report_mismatch("degenerate", 32'(out_data.degenerate),
						32'(want.degenerate));
				if (want.degenerate) degenerate_count++;
				else resolved_count++;
			end
		end
	end

	// Drive the stimulus
	initial begin
		decr_out_t table_exp;
		build_table();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table; the pass-through results of flagged rows must agree with the predictor
		foreach (table_rows[i]) begin
			if (table_rows[i].has_exp) begin
				table_exp = resolve_pair(table_rows[i].item);
				if (table_exp !== table_rows[i].exp) begin
					report_mismatch("typed table result", table_exp.new_a_pos_x,
						table_rows[i].exp.new_a_pos_x);
				end
			end
			send_pair(table_rows[i].item);
		end

		// Random pairs, with a calm stretch in the middle
		for (int n = 0; n < N_RANDOM; n++) begin
			calm_mode = (n >= 300 && n < 420);
			if (n == 500) begin
				// hold off until the pipeline drains
				in_valid <= 1'b0;
				@(posedge clk);
				while (pending_pairs.size() != 0) @(posedge clk);
			end
			send_pair(random_pair());
		end
		in_valid <= 1'b0;
		calm_mode = 1'b0;

		while (pending_pairs.size() != 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);

		$display("covered %0d resolved and %0d degenerate pairs, with random idles and stalls",
			resolved_count, degenerate_count);
		if (mismatch_count == 0) begin
			$display("disc_elastic_collision_resolve_top verification clean");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("disc_elastic_collision_resolve_top verification failed");
		end
		$finish;
	end

endmodule
